>>> hdl/cbim_pkg.sv
// ----------------------------------------------------------------------------
// cbim_pkg
// Shared types and constants of the bin interval maker: field widths,
// mode and status codes, register indexes and controller/datapath links.
// ----------------------------------------------------------------------------
package cbim_pkg;

   // field and arithmetic widths
   localparam int LW   = 30;            // length fields
   localparam int OW   = 32;            // signed position outputs
   localparam int NW   = LW + 1;        // bin count
   localparam int AW   = 34;            // signed working width
   localparam int FW   = 9;             // Q1.8 fraction
   localparam int PW   = LW + FW;       // fraction times length
   localparam int IW   = 3;             // register index
   localparam int DW   = 32;            // register write data
   localparam int CNTW = $clog2(LW + 1);

   localparam logic signed [AW-1:0] WIDEN = AW'(100);

   // mode codes
   localparam logic [1:0] MODE_EQ0 = 2'd0;
   localparam logic [1:0] MODE_EQ  = 2'd1;
   localparam logic [1:0] MODE_HT  = 2'd2;
   localparam logic [1:0] MODE_ONE = 2'd3;

   // status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_NOFIT = 2'd1;
   localparam logic [1:0] ST_TRUNC = 2'd2;

   // register indexes
   localparam logic [IW-1:0] CSR_MODE = 3'd0;
   localparam logic [IW-1:0] CSR_BLEN = 3'd1;
   localparam logic [IW-1:0] CSR_TRIM = 3'd2;
   localparam logic [IW-1:0] CSR_EDGE = 3'd3;
   localparam logic [IW-1:0] CSR_FRAC = 3'd4;

   typedef enum logic [2:0] {
      EMIT_NONE,
      EMIT_M3,
      EMIT_M2A,
      EMIT_M2B,
      EMIT_ERR,
      EMIT_SGL,
      EMIT_HEAD,
      EMIT_TAIL
   } emit_type;

   typedef struct packed {
      logic [1:0]    mode;
      logic [LW-1:0] bin_length;
      logic [LW-1:0] tail_trim;
      logic [LW-1:0] edge_limit;
      logic [FW-1:0] frac;
   } cfg_type;

   typedef struct packed {
      logic     load;
      logic     m2_calc;
      logic     div_start;
      logic     ncalc;
      logic     head_init;
      logic     tsel;
      logic     tmul;
      logic     tinit;
      emit_type emit;
   } cmd_type;

   typedef struct packed {
      logic mode_one;
      logic mode_ht;
      logic u_neg;
      logic div_done;
      logic n_zero;
      logic n_one;
      logic head_ok;
      logic head_last;
      logic k_zero;
      logic tail_last;
   } stat_type;

endpackage

>>> hdl/contig_bin_interval_maker.sv
// Order: one-bin mode, and a negative used length in equal-bin mode, give the
// result from the dispatch step; head-tail mode gives two results in turn;
// equal-bin mode runs the divider first, then gives a lone bin or no-fit result
// or one bin per cycle, with a gap between head and tail for tail-walker setup.
// Throughput: one transaction at a time; busy drops as the final result strobes.
// Reset: synchronous, active high; config and control state reset; no stalls.
// ----------------------------------------------------------------------------
// contig_bin_interval_maker
// Cuts a trimmed sequence length into position bins per the configured mode.
// ----------------------------------------------------------------------------
module contig_bin_interval_maker #(
   parameter int MAX_BINS = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [cbim_pkg::LW-1:0]        req_seq_length,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [cbim_pkg::IW-1:0]        csr_index,
   input  logic [cbim_pkg::DW-1:0]        csr_wdata,
   output logic                           rsp_valid,
   output logic [cbim_pkg::LW-1:0]        rsp_bin_index,
   output logic signed [cbim_pkg::OW-1:0] rsp_bin_start,
   output logic signed [cbim_pkg::OW-1:0] rsp_bin_end,
   output logic [1:0]                     rsp_status,
   output logic                           rsp_last
);
   import cbim_pkg::*;

   cfg_type  cfg_ff;
   cmd_type  cmd;
   stat_type stat;

   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode       <= MODE_EQ;
         cfg_ff.bin_length <= LW'(1000);
         cfg_ff.tail_trim  <= '0;
         cfg_ff.edge_limit <= LW'(15000);
         cfg_ff.frac       <= FW'(128);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_MODE: cfg_ff.mode       <= csr_wdata[1:0];
            CSR_BLEN: cfg_ff.bin_length <= csr_wdata[LW-1:0];
            CSR_TRIM: cfg_ff.tail_trim  <= csr_wdata[LW-1:0];
            CSR_EDGE: cfg_ff.edge_limit <= csr_wdata[LW-1:0];
            CSR_FRAC: cfg_ff.frac       <= csr_wdata[FW-1:0];
            default:  cfg_ff            <= cfg_ff;
         endcase
      end
   end

   cbim_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   cbim_dp #(
      .MAX_BINS (MAX_BINS)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .seq_length    (req_seq_length),
      .cmd           (cmd),
      .stat          (stat),
      .rsp_valid     (rsp_valid),
      .rsp_bin_index (rsp_bin_index),
      .rsp_bin_start (rsp_bin_start),
      .rsp_bin_end   (rsp_bin_end),
      .rsp_status    (rsp_status),
      .rsp_last      (rsp_last)
   );

`ifndef SYNTH
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |=> !rsp_valid)
      else $error("result after final result of a transaction");
   a_trunc_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_TRUNC) |-> rsp_last)
      else $error("truncation status on a non-final result");
   a_nofit_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_NOFIT) |-> rsp_last && (rsp_bin_index == '0))
      else $error("no-fit status must be a lone result");
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted transaction did not raise busy");
`endif

endmodule

>>> hdl/cbim_div.sv
// ----------------------------------------------------------------------------
// cbim_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cbim_div (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [cbim_pkg::LW-1:0] dividend,
   input  logic [cbim_pkg::LW-1:0] divisor,
   output logic [cbim_pkg::LW-1:0] quo,
   output logic [cbim_pkg::LW-1:0] rem,
   output logic                   done
);
   import cbim_pkg::*;

   logic [LW:0]     rem_ff, rem_in;
   logic [LW-1:0]   quo_ff, quo_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic            run_ff, run_in;
   logic            done_ff, done_in;
   logic [LW:0]     shifted;
   logic [LW:0]     trial;

   // one restoring step
   always_comb begin
      shifted = {rem_ff[LW-1:0], quo_ff[LW-1]};
      trial   = shifted - {1'b0, divisor};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = done_ff;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         cnt_in  = CNTW'(LW);
         run_in  = 1'b1;
         done_in = 1'b0;
      end else if (run_ff) begin
         if (shifted >= {1'b0, divisor}) begin
            rem_in = trial;
            quo_in = {quo_ff[LW-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[LW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNTW'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (reset) begin
         cnt_ff  <= '0;
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign quo  = quo_ff;
   assign rem  = rem_ff[LW-1:0];
   assign done = done_ff;

endmodule

>>> hdl/cbim_ctrl.sv
// ----------------------------------------------------------------------------
// cbim_ctrl
// Sequencer: walks one transaction through load, count and bin emission.
// ----------------------------------------------------------------------------
module cbim_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  cbim_pkg::stat_type stat,
   output cbim_pkg::cmd_type  cmd
);
   import cbim_pkg::*;

   typedef enum logic [10:0] {
      S_IDLE  = 11'b000_0000_0001,
      S_DISP  = 11'b000_0000_0010,
      S_M2A   = 11'b000_0000_0100,
      S_M2B   = 11'b000_0000_1000,
      S_DIV   = 11'b000_0001_0000,
      S_NCALC = 11'b000_0010_0000,
      S_CLASS = 11'b000_0100_0000,
      S_HEAD  = 11'b000_1000_0000,
      S_TMUL  = 11'b001_0000_0000,
      S_TINIT = 11'b010_0000_0000,
      S_TAIL  = 11'b100_0000_0000
   } state_type;

   state_type state_ff, state_in;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.emit = EMIT_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            if (stat.mode_one) begin
               cmd.emit = EMIT_M3;
               state_in = S_IDLE;
            end else if (stat.mode_ht) begin
               cmd.m2_calc = 1'b1;
               state_in    = S_M2A;
            end else if (stat.u_neg) begin
               cmd.emit = EMIT_ERR;
               state_in = S_IDLE;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = S_DIV;
            end
         end
         S_M2A: begin
            cmd.emit = EMIT_M2A;
            state_in = S_M2B;
         end
         S_M2B: begin
            cmd.emit = EMIT_M2B;
            state_in = S_IDLE;
         end
         S_DIV: begin
            if (stat.div_done) state_in = S_NCALC;
         end
         S_NCALC: begin
            cmd.ncalc = 1'b1;
            state_in  = S_CLASS;
         end
         S_CLASS: begin
            if (stat.n_zero) begin
               cmd.emit = EMIT_ERR;
               state_in = S_IDLE;
            end else if (stat.n_one) begin
               cmd.emit = EMIT_SGL;
               state_in = S_IDLE;
            end else begin
               cmd.head_init = 1'b1;
               state_in      = S_HEAD;
            end
         end
         S_HEAD: begin
            if (stat.head_ok) begin
               cmd.emit = EMIT_HEAD;
               if (stat.head_last) state_in = S_IDLE;
            end else if (stat.k_zero) begin
               cmd.emit = EMIT_ERR;
               state_in = S_IDLE;
            end else begin
               cmd.tsel = 1'b1;
               state_in = S_TMUL;
            end
         end
         S_TMUL: begin
            cmd.tmul = 1'b1;
            state_in = S_TINIT;
         end
         S_TINIT: begin
            cmd.tinit = 1'b1;
            state_in  = S_TAIL;
         end
         S_TAIL: begin
            cmd.emit = EMIT_TAIL;
            if (stat.tail_last) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   assign busy = (state_ff != S_IDLE);

endmodule

>>> hdl/cbim_dp.sv
// ----------------------------------------------------------------------------
// cbim_dp
// Datapath: used length, bin count, head/tail walkers and result registers.
// ----------------------------------------------------------------------------
module cbim_dp #(
   parameter int MAX_BINS = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  cbim_pkg::cfg_type             cfg,
   input  logic [cbim_pkg::LW-1:0]       seq_length,
   input  cbim_pkg::cmd_type             cmd,
   output cbim_pkg::stat_type            stat,
   output logic                          rsp_valid,
   output logic [cbim_pkg::LW-1:0]       rsp_bin_index,
   output logic signed [cbim_pkg::OW-1:0] rsp_bin_start,
   output logic signed [cbim_pkg::OW-1:0] rsp_bin_end,
   output logic [1:0]                    rsp_status,
   output logic                          rsp_last
);
   import cbim_pkg::*;

   localparam int KW = (MAX_BINS > 2) ? $clog2(MAX_BINS) : 1;
   localparam logic [KW-1:0] K_LAST = KW'(MAX_BINS - 1);

   logic signed [AW-1:0] u_ff, e1a_ff, s2a_ff, uml1_ff, dm_ff, sgl_ff;
   logic signed [AW-1:0] he_ff, prod_ff, te_ff;
   logic [LW-1:0]        len_ff;
   logic [PW-1:0]        pfp_ff;
   logic [NW-1:0]        n_ff, hsteps_ff, t_ff, m_ff;
   logic [KW-1:0]        k_ff;
   logic [LW+2:0]        hs_ff;

   logic signed [AW-1:0] len_s, lim_s, u_adj, half, e1;
   logic signed [AW-1:0] d_adj, e1c, s2c, ts;
   logic [LW-1:0]        quo, rem;
   logic                 div_done, frac_ok, k_below;
   logic [NW-1:0]        n_in;

   cbim_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (u_ff[LW-1:0]),
      .divisor  (len_ff),
      .quo      (quo),
      .rem      (rem),
      .done     (div_done)
   );

   // derived operands
   always_comb begin
      len_s   = $signed(AW'(len_ff));
      lim_s   = $signed(AW'(cfg.edge_limit));
      u_adj   = u_ff + $signed({{(AW-1){1'b0}}, u_ff[AW-1]});
      half    = u_adj >>> 1;
      e1      = half - AW'(1);
      d_adj   = dm_ff + $signed({{(AW-1){1'b0}}, dm_ff[AW-1]});
      frac_ok = ({1'b0, rem, 8'b0} >= pfp_ff);
      n_in    = {1'b0, quo} + NW'(frac_ok);
      e1c     = (e1a_ff > len_s) ? len_s : e1a_ff;
      s2c     = (s2a_ff < uml1_ff) ? uml1_ff : s2a_ff;
      ts      = te_ff - len_s + AW'(1);
      k_below = (NW'(k_ff) < hsteps_ff);
   end

   // status to the sequencer
   always_comb begin
      stat.mode_one  = (cfg.mode == MODE_ONE);
      stat.mode_ht   = (cfg.mode == MODE_HT);
      stat.u_neg     = u_ff[AW-1];
      stat.div_done  = div_done;
      stat.n_zero    = (n_ff == '0);
      stat.n_one     = (n_ff == NW'(1));
      stat.head_ok   = k_below && (hs_ff <= (LW+3)'(cfg.edge_limit));
      stat.head_last = (k_ff == K_LAST);
      stat.k_zero    = (k_ff == '0);
      stat.tail_last = (m_ff == n_ff - NW'(1)) || (k_ff == K_LAST);
   end

   // working registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         u_ff   <= $signed(AW'(seq_length)) - $signed(AW'(cfg.tail_trim));
         len_ff <= (cfg.bin_length == '0) ? LW'(1) : cfg.bin_length;
      end
      if (cmd.m2_calc) begin
         uml1_ff <= u_ff - len_s + AW'(1);
         if (e1 > lim_s) begin
            e1a_ff <= lim_s;
            s2a_ff <= u_ff - lim_s + AW'(1);
         end else begin
            e1a_ff <= e1;
            s2a_ff <= half;
         end
      end
      if (cmd.div_start) begin
         pfp_ff <= PW'(cfg.frac) * PW'(len_ff);
         dm_ff  <= u_ff - AW'(1) - len_s;
      end
      if (cmd.ncalc) begin
         n_ff   <= n_in;
         sgl_ff <= (d_adj >>> 1) + AW'(1);
      end
      // initialise head walker; advance bin counter on head and tail bins
      if (cmd.head_init) begin
         k_ff      <= '0;
         hs_ff     <= (LW+3)'(1);
         he_ff     <= len_s;
         hsteps_ff <= (n_ff + NW'(1)) >> 1;
      end else if (cmd.emit == EMIT_HEAD || cmd.emit == EMIT_TAIL) begin
         k_ff <= k_ff + KW'(1);
      end
      if (cmd.emit == EMIT_HEAD) begin
         hs_ff <= hs_ff + (LW+3)'(len_ff);
         he_ff <= he_ff + len_s;
      end
      // set up and advance tail walker
      if (cmd.tsel) t_ff <= k_below ? NW'(k_ff) : (n_ff >> 1);
      if (cmd.tmul) begin
         prod_ff <= AW'(LW'(t_ff - NW'(1)) * (2*LW)'(len_ff));
         m_ff    <= n_ff - t_ff;
      end
      if (cmd.tinit) te_ff <= u_ff - prod_ff;
      if (cmd.emit == EMIT_TAIL) begin
         m_ff  <= m_ff + NW'(1);
         te_ff <= te_ff + len_s;
      end
   end

   // result registers
   always_ff @(posedge clock) begin
      unique case (cmd.emit)
         EMIT_M3: begin
            rsp_bin_index <= '0;
            rsp_bin_start <= OW'(-WIDEN);
            rsp_bin_end   <= OW'(u_ff + WIDEN);
            rsp_status    <= ST_OK;
            rsp_last      <= 1'b1;
         end
         EMIT_M2A: begin
            rsp_bin_index <= '0;
            rsp_bin_start <= OW'(1);
            rsp_bin_end   <= OW'(e1c);
            rsp_status    <= ST_OK;
            rsp_last      <= 1'b0;
         end
         EMIT_M2B: begin
            rsp_bin_index <= LW'(1);
            rsp_bin_start <= OW'(s2c);
            rsp_bin_end   <= OW'(u_ff);
            rsp_status    <= ST_OK;
            rsp_last      <= 1'b1;
         end
         EMIT_ERR: begin
            rsp_bin_index <= '0;
            rsp_bin_start <= '0;
            rsp_bin_end   <= '0;
            rsp_status    <= ST_NOFIT;
            rsp_last      <= 1'b1;
         end
         EMIT_SGL: begin
            rsp_bin_index <= '0;
            rsp_bin_start <= OW'(sgl_ff);
            rsp_bin_end   <= OW'(sgl_ff + len_s - AW'(1));
            rsp_status    <= ST_OK;
            rsp_last      <= 1'b1;
         end
         EMIT_HEAD: begin
            rsp_bin_index <= LW'(k_ff);
            rsp_bin_start <= OW'(hs_ff);
            rsp_bin_end   <= OW'(he_ff);
            rsp_status    <= stat.head_last ? ST_TRUNC : ST_OK;
            rsp_last      <= stat.head_last;
         end
         EMIT_TAIL: begin
            rsp_bin_index <= LW'(m_ff);
            rsp_bin_start <= OW'(ts);
            rsp_bin_end   <= OW'(te_ff);
            rsp_status    <= ((k_ff == K_LAST) && (m_ff != n_ff - NW'(1)))
                             ? ST_TRUNC : ST_OK;
            rsp_last      <= stat.tail_last;
         end
         default: begin
            rsp_bin_index <= rsp_bin_index;
            rsp_bin_start <= rsp_bin_start;
            rsp_bin_end   <= rsp_bin_end;
            rsp_status    <= rsp_status;
            rsp_last      <= rsp_last;
         end
      endcase
   end

   // strobe one cycle per result
   always_ff @(posedge clock) begin
      if (reset) rsp_valid <= 1'b0;
      else       rsp_valid <= (cmd.emit != EMIT_NONE);
   end

endmodule
